// ===== sv/amrc_pkg.sv =====
// Package for the adaptive mutation-rate controller.
// Holds sizes, register indexes, the controller states and the control structs.
// No dependencies.
`default_nettype none
package amrc_pkg;

  // The history depth must be a power of two: the mean and the deviation are floor shifts.
  localparam int HIST_DEPTH = 16;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int CNT_W      = $clog2(HIST_DEPTH + 1);
  localparam int FIT_W      = 32;
  localparam int SUM_W      = FIT_W + HIST_AW;
  localparam int RATE_W     = 16;
  localparam int LEN_W      = 16;
  localparam int THR_W      = 31;
  localparam int STAGE_W    = 18;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_RATE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STAGE_ONE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STAGE_TWO   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STAGE_THREE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STAGE_FOUR  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STAGE_LEN   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_CYCLE  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_STALL_THR   = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_SUM_END,
    ST_MEAN,
    ST_DEV,
    ST_DEV_END,
    ST_DECIDE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [RATE_W-1:0] base_rate;
    logic [RATE_W-1:0] stage_one_rate;
    logic [RATE_W-1:0] stage_two_rate;
    logic [RATE_W-1:0] stage_three_rate;
    logic [RATE_W-1:0] stage_four_rate;
    logic [LEN_W-1:0]  stage_length;
    logic              full_cycle_mode;
    logic [THR_W-1:0]  stall_threshold;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic rd_issue;
    logic pass_dev;
    logic mean_ld;
    logic decide;
    logic out_ld;
  } cmd_t;

  typedef struct packed {
    logic hist_full;
    logic rd_last;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// ===== sv/amrc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module amrc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/amrc_ctrl.sv =====
// Sequencer for the mutation-rate controller: accept, two history passes and decide once full, hand off.
// Depends on amrc_pkg.
`default_nettype none
module amrc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire amrc_pkg::status_t status,
  output      amrc_pkg::cmd_t    cmd,
  output      logic              idle
);
  import amrc_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = status.hist_full ? ST_SUM : ST_DONE;
        end
      end
      ST_SUM: begin
        if (status.rd_last) begin
          state_next = ST_SUM_END;
        end
      end
      ST_SUM_END: state_next = ST_MEAN;
      ST_MEAN:    state_next = ST_DEV;
      ST_DEV: begin
        if (status.rd_last) begin
          state_next = ST_DEV_END;
        end
      end
      ST_DEV_END: state_next = ST_DECIDE;
      ST_DECIDE:  state_next = ST_DONE;
      ST_DONE: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    idle = 1'b0;
    case (state)
      ST_IDLE: begin
        idle       = 1'b1;
        cmd.accept = in_valid;
      end
      ST_SUM:     cmd.rd_issue = 1'b1;
      ST_MEAN:    cmd.mean_ld = 1'b1;
      ST_DEV: begin
        cmd.rd_issue = 1'b1;
        cmd.pass_dev = 1'b1;
      end
      ST_DECIDE:  cmd.decide = 1'b1;
      ST_DONE:    cmd.out_ld = status.out_free;
      default:    cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/amrc_dpath.sv =====
// Datapath: ring pointers, mean and deviation accumulators, stage walk, output register.
// Depends on amrc_pkg; the history RAM sits outside.
`default_nettype none
module amrc_dpath (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire amrc_pkg::cmd_t                    cmd,
  input  wire amrc_pkg::cfg_t                    cfg,
  output      amrc_pkg::status_t                 status,
  output      logic [amrc_pkg::HIST_AW-1:0]      write_slot,
  output      logic [amrc_pkg::HIST_AW-1:0]      rd_idx,
  input  wire logic [amrc_pkg::FIT_W-1:0]        rd_data,
  output      logic                              out_valid,
  input  wire logic                              out_stall,
  output      logic [amrc_pkg::RATE_W-1:0]       mutation_rate,
  output      logic [amrc_pkg::FIT_W-1:0]        deviation,
  output      logic                              deviation_valid
);
  import amrc_pkg::*;

  logic [CNT_W-1:0]        gen_count;
  logic [STAGE_W-1:0]      stage_cnt;
  logic                    latched;
  logic                    rd_pend;
  logic                    rd_pass;
  logic signed [SUM_W-1:0] sum;
  logic signed [FIT_W-1:0] mean;
  logic [SUM_W-1:0]        acc;
  logic [RATE_W-1:0]       res_rate;
  logic [FIT_W-1:0]        res_dev;
  logic                    res_dv;

  logic                    hist_full;
  logic signed [FIT_W:0]   diff;
  logic [FIT_W:0]          diff_abs;
  logic [FIT_W-1:0]        dev;
  logic                    stalled;
  logic [STAGE_W-1:0]      len1;
  logic [STAGE_W-1:0]      len2;
  logic [STAGE_W-1:0]      len3;
  logic [STAGE_W-1:0]      len4;
  logic [STAGE_W-1:0]      cnt_inc;
  logic                    latch_eff;
  logic                    do_walk;
  logic [RATE_W-1:0]       rate_next;
  logic [STAGE_W-1:0]      stage_cnt_next;
  logic                    latched_next;

  assign hist_full       = (gen_count == CNT_W'(HIST_DEPTH));
  assign status.hist_full = hist_full;
  assign status.rd_last   = (rd_idx == HIST_AW'(HIST_DEPTH - 1));
  assign status.out_free  = !out_valid || !out_stall;

  assign diff     = {mean[FIT_W-1], mean} - {rd_data[FIT_W-1], rd_data};
  assign diff_abs = diff[FIT_W] ? (FIT_W + 1)'(-diff) : diff;
  assign dev      = FIT_W'(acc >> HIST_AW);
  assign stalled  = dev < {1'b0, cfg.stall_threshold};

  assign len1    = STAGE_W'(cfg.stage_length);
  assign len2    = len1 << 1;
  assign len3    = len2 + len1;
  assign len4    = len1 << 2;
  assign cnt_inc = stage_cnt + STAGE_W'(1);

  always_comb begin
    latch_eff      = cfg.full_cycle_mode && (latched || stalled);
    do_walk        = cfg.full_cycle_mode ? latch_eff : stalled;
    rate_next      = cfg.base_rate;
    stage_cnt_next = stage_cnt;
    latched_next   = cfg.full_cycle_mode ? latch_eff : latched;
    if (do_walk) begin
      if (stage_cnt >= len4) begin
        stage_cnt_next = '0;
        latched_next   = 1'b0;
      end else begin
        if (stage_cnt < len1) begin
          rate_next = cfg.stage_one_rate;
        end else if (stage_cnt < len2) begin
          rate_next = cfg.stage_two_rate;
        end else if (stage_cnt < len3) begin
          rate_next = cfg.stage_three_rate;
        end else begin
          rate_next = cfg.stage_four_rate;
        end
        if (cnt_inc == len4) begin
          stage_cnt_next = '0;
          latched_next   = 1'b0;
        end else begin
          stage_cnt_next = cnt_inc;
        end
      end
    end else if (!cfg.full_cycle_mode) begin
      stage_cnt_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_count  <= '0;
      write_slot <= '0;
      stage_cnt  <= '0;
      latched    <= 1'b0;
      rd_pend    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      rd_pend <= cmd.rd_issue;
      if (cmd.accept) begin
        write_slot <= (write_slot == HIST_AW'(HIST_DEPTH - 1)) ? '0
                                                                : write_slot + HIST_AW'(1);
        if (!hist_full) begin
          gen_count <= gen_count + CNT_W'(1);
        end
      end
      if (cmd.decide) begin
        stage_cnt <= stage_cnt_next;
        latched   <= latched_next;
      end
      if (cmd.out_ld) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_pass <= cmd.pass_dev;
    if (cmd.accept || cmd.mean_ld) begin
      rd_idx <= '0;
    end else if (cmd.rd_issue) begin
      rd_idx <= rd_idx + HIST_AW'(1);
    end
    if (cmd.accept) begin
      sum <= '0;
    end else if (rd_pend && !rd_pass) begin
      sum <= sum + SUM_W'(signed'(rd_data));
    end
    if (cmd.mean_ld) begin
      mean <= FIT_W'(sum >>> HIST_AW);
      acc  <= '0;
    end else if (rd_pend && rd_pass) begin
      acc <= acc + SUM_W'(diff_abs[FIT_W-1:0]);
    end
    if (cmd.accept && !hist_full) begin
      res_rate <= cfg.base_rate;
      res_dev  <= '0;
      res_dv   <= 1'b0;
    end else if (cmd.decide) begin
      res_rate <= rate_next;
      res_dev  <= dev;
      res_dv   <= 1'b1;
    end
    if (cmd.out_ld) begin
      mutation_rate   <= res_rate;
      deviation       <= res_dev;
      deviation_valid <= res_dv;
    end
  end

endmodule
`default_nettype wire

// ===== sv/adaptive_mutation_rate_controller_top.sv =====
// Top level of the adaptive mutation-rate controller: config registers and block wiring.
// Depends on amrc_pkg, amrc_ram, amrc_ctrl and amrc_dpath.
//
//   port group     dir   handshake             payload
//   input item     in    in_valid / in_stall   best_fitness
//   result item    out   out_valid / out_stall mutation_rate, deviation, deviation_valid
//   config write   in    cfg_write             cfg_index, cfg_data
//
// Until the history holds 16 generations an item skips the history passes; after that
// it makes two passes of 16 reads each through the single read port of the history RAM.
// The next item is taken while a result waits in the output register.
// Reset is synchronous and restores the register defaults; the history RAM is not cleared.
// A stalled result holds the sequencer in its last state once the next result is ready.
`default_nettype none
module adaptive_mutation_rate_controller_top (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output      logic                                 in_stall,
  input  wire logic signed [amrc_pkg::FIT_W-1:0]    best_fitness,
  output      logic                                 out_valid,
  input  wire logic                                 out_stall,
  output      logic [amrc_pkg::RATE_W-1:0]          mutation_rate,
  output      logic [amrc_pkg::FIT_W-1:0]           deviation,
  output      logic                                 deviation_valid,
  input  wire logic                                 cfg_write,
  input  wire logic [amrc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [amrc_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import amrc_pkg::*;

  cfg_t               cfg;
  cmd_t               cmd;
  status_t            status;
  logic               idle;
  logic [HIST_AW-1:0] write_slot;
  logic [HIST_AW-1:0] rd_idx;
  logic [FIT_W-1:0]   rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_rate        <= RATE_W'(1);
      cfg.stage_one_rate   <= RATE_W'(1);
      cfg.stage_two_rate   <= RATE_W'(2);
      cfg.stage_three_rate <= RATE_W'(5);
      cfg.stage_four_rate  <= RATE_W'(10);
      cfg.stage_length     <= LEN_W'(10);
      cfg.full_cycle_mode  <= 1'b1;
      cfg.stall_threshold  <= THR_W'(655);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BASE_RATE:   cfg.base_rate        <= cfg_data[RATE_W-1:0];
        REG_STAGE_ONE:   cfg.stage_one_rate   <= cfg_data[RATE_W-1:0];
        REG_STAGE_TWO:   cfg.stage_two_rate   <= cfg_data[RATE_W-1:0];
        REG_STAGE_THREE: cfg.stage_three_rate <= cfg_data[RATE_W-1:0];
        REG_STAGE_FOUR:  cfg.stage_four_rate  <= cfg_data[RATE_W-1:0];
        REG_STAGE_LEN:   cfg.stage_length     <= cfg_data[LEN_W-1:0];
        REG_FULL_CYCLE:  cfg.full_cycle_mode  <= cfg_data[0];
        REG_STALL_THR:   cfg.stall_threshold  <= cfg_data[THR_W-1:0];
        default:         cfg <= cfg;
      endcase
    end
  end

  assign in_stall = !idle;

  amrc_ram #(
    .WIDTH (FIT_W),
    .DEPTH (HIST_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (cmd.accept),
    .waddr (write_slot),
    .wdata (best_fitness),
    .raddr (rd_idx),
    .rdata (rd_data)
  );

  amrc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .cmd      (cmd),
    .idle     (idle)
  );

  amrc_dpath u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .cfg             (cfg),
    .status          (status),
    .write_slot      (write_slot),
    .rd_idx          (rd_idx),
    .rd_data         (rd_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .mutation_rate   (mutation_rate),
    .deviation       (deviation),
    .deviation_valid (deviation_valid)
  );

endmodule
`default_nettype wire
